/* rtl/car_pkg.sv */
`default_nettype none

package car_pkg;

    // table geometry
    localparam int BUCKETS = 4096;
    localparam int SLOTS   = 1024;
    localparam int PC_W    = 32;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int NF_W    = SLOT_W + 1;
    localparam int STEP_W  = SLOT_W + 1;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 12;
    localparam int OP_W    = 2;
    localparam int SPAN_W  = 14;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_RECORD  = 2'd0;
    localparam logic [OP_W-1:0] OP_RD_HEAD = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_SLOT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_TEXT_BASE = 2'd0;
    localparam logic [1:0] REG_TEXT_SPAN = 2'd1;
    localparam logic [1:0] REG_ARC_LIMIT = 2'd2;
    localparam logic [1:0] REG_ENABLE    = 2'd3;

    localparam logic [NF_W-1:0] ARC_LIMIT_RST = NF_W'(SLOTS);

    typedef enum logic [2:0] {
        ST_HEAD  = 3'd0,
        ST_MOVED = 3'd1,
        ST_NEW   = 3'd2,
        ST_RANGE = 3'd3,
        ST_OVF   = 3'd4,
        ST_OFF   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_HEAD,
        S_RD_SLOT,
        S_HEAD,
        S_CMP_HEAD,
        S_WALK,
        S_WCMP,
        S_MOVE1,
        S_MOVE2,
        S_ALLOC
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [PC_W-1:0]  caller_pc;
        logic [PC_W-1:0]  callee_pc;
        logic [IDX_W-1:0] index;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [PC_W-1:0]   callee_out;
        logic [CNT_W-1:0]  arc_count;
        logic [SLOT_W-1:0] next_link;
    } t_result;

    // saturating count increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/call_arc_recorder.sv */
`default_nettype none

// Call arc recorder for a call-graph profiler.
// Items enter on a command channel: put an item on i_item and raise start;
// it is taken at the clock edge where start is high and busy is low. Each
// item gives exactly one result on o_result, valid for the single cycle in
// which o_done is high; the receiver cannot hold results off.
// A record hashes the caller offset into a bucket, walks the bucket's chain
// of arc slots one slot at a time through S_WALK and S_WCMP with one compare
// unit, and then bumps, moves to front or allocates a slot.
// Reads and rejected records finish from S_DECODE or a read state, a head hit
// from S_CMP_HEAD, a new arc or an overflow from S_ALLOC after the walk, and
// a moved hit from S_MOVE2 after the walk. The walk through the slot
// memories, one read port, sets the rate; busy stays high for the whole item.
// Registers (text_base, text_span, arc_limit, enable) are written over the
// APB port at byte addresses 0, 4, 8, 12; the user must write them only while
// the block is idle, which the block itself does not enforce. After reset the
// bucket head memory is cleared one entry a cycle over all 4096 buckets, and
// busy stays high until that pass ends; register writes are accepted during it.

module call_arc_recorder (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  car_pkg::t_item          i_item,
    output logic                          o_done,
    output car_pkg::t_result              o_result,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [car_pkg::ADDR_W-1:0]    paddr,
    input  wire  [car_pkg::DATA_W-1:0]    pwdata,
    output logic [car_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import car_pkg::*;

    // memories
    logic [SLOT_W-1:0] r_head_mem   [BUCKETS];
    logic [PC_W-1:0]   r_callee_mem [SLOTS];
    logic [CNT_W-1:0]  r_count_mem  [SLOTS];
    logic [SLOT_W-1:0] r_link_mem   [SLOTS];

    logic [SLOT_W-1:0] r_hq;
    logic [PC_W-1:0]   r_cq;
    logic [CNT_W-1:0]  r_nq;
    logic [SLOT_W-1:0] r_lq;

    // configuration
    logic [PC_W-1:0]   r_text_base;
    logic [SPAN_W-1:0] r_text_span;
    logic [NF_W-1:0]   r_arc_limit;
    logic              r_enable;

    // sequencer state
    t_state            r_state,     n_state;
    logic [OP_W-1:0]   r_op,        n_op;
    logic [PC_W-1:0]   r_caller,    n_caller;
    logic [PC_W-1:0]   r_callee,    n_callee;
    logic [IDX_W-1:0]  r_index,     n_index;
    logic [BKT_W-1:0]  r_bkt,       n_bkt;
    logic [SLOT_W-1:0] r_head,      n_head;
    logic [SLOT_W-1:0] r_prev,      n_prev;
    logic [SLOT_W-1:0] r_cur,       n_cur;
    logic [STEP_W-1:0] r_steps,     n_steps;
    logic [CNT_W-1:0]  r_cnt,       n_cnt;
    logic [SLOT_W-1:0] r_nlink,     n_nlink;
    logic [BKT_W-1:0]  r_clr,       n_clr;
    logic [NF_W-1:0]   r_next_free, n_next_free;
    logic              r_halted,    n_halted;
    logic              r_done,      n_done;
    t_result           r_res,       n_res;

    // memory access controls
    logic [BKT_W-1:0]  head_raddr;
    logic [SLOT_W-1:0] slot_raddr;
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [SLOT_W-1:0] head_wdata;
    logic              slot_we;
    logic              cnt_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [PC_W-1:0]   callee_wdata;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;

    logic [PC_W-1:0]   offset;
    logic [NF_W:0]     alloc_idx;
    logic [CNT_W-1:0]  cnt_bumped;
    logic              cfg_wr;

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_waddr] <= head_wdata;
        end
        r_hq <= r_head_mem[head_raddr];
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_callee_mem[slot_waddr] <= callee_wdata;
        end
        if (cnt_we) begin
            r_count_mem[slot_waddr] <= cnt_wdata;
        end
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_cq <= r_callee_mem[slot_raddr];
        r_nq <= r_count_mem[slot_raddr];
        r_lq <= r_link_mem[slot_raddr];
    end

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_base <= '0;
            r_text_span <= '0;
            r_arc_limit <= ARC_LIMIT_RST;
            r_enable    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TEXT_BASE: r_text_base <= pwdata[PC_W-1:0];
                REG_TEXT_SPAN: r_text_span <= pwdata[SPAN_W-1:0];
                REG_ARC_LIMIT: r_arc_limit <= pwdata[NF_W-1:0];
                REG_ENABLE:    r_enable    <= pwdata[0];
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TEXT_BASE: prdata = DATA_W'(r_text_base);
            REG_TEXT_SPAN: prdata = DATA_W'(r_text_span);
            REG_ARC_LIMIT: prdata = DATA_W'(r_arc_limit);
            REG_ENABLE:    prdata = DATA_W'(r_enable);
            default:       prdata = '0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= '0;
            r_halted    <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_halted    <= n_halted;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_caller <= n_caller;
        r_callee <= n_callee;
        r_index  <= n_index;
        r_bkt    <= n_bkt;
        r_head   <= n_head;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_steps  <= n_steps;
        r_cnt    <= n_cnt;
        r_nlink  <= n_nlink;
        r_res    <= n_res;
    end

    assign offset     = r_caller - r_text_base;
    assign alloc_idx  = {1'b0, r_next_free} + (NF_W+1)'(1);
    assign cnt_bumped = sat_inc(r_nq);

    // sequencer: next state, memory controls and result
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_caller    = r_caller;
        n_callee    = r_callee;
        n_index     = r_index;
        n_bkt       = r_bkt;
        n_head      = r_head;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_cnt       = r_cnt;
        n_nlink     = r_nlink;
        n_clr       = r_clr;
        n_next_free = r_next_free;
        n_halted    = r_halted;
        n_done      = 1'b0;
        n_res       = r_res;

        head_raddr   = r_bkt;
        slot_raddr   = r_cur;
        head_we      = 1'b0;
        head_waddr   = r_bkt;
        head_wdata   = r_cur;
        slot_we      = 1'b0;
        cnt_we       = 1'b0;
        slot_waddr   = r_cur;
        callee_wdata = r_callee;
        cnt_wdata    = r_cnt;
        link_we      = 1'b0;
        link_waddr   = r_prev;
        link_wdata   = r_nlink;

        unique case (r_state)
            // sweep the bucket heads to empty chains
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
                n_clr      = r_clr + BKT_W'(1);
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // take a new transaction
            S_IDLE: begin
                if (start) begin
                    n_op     = i_item.opcode;
                    n_caller = i_item.caller_pc;
                    n_callee = i_item.callee_pc;
                    n_index  = i_item.index;
                    n_state  = S_DECODE;
                end
            end

            // range checks and first memory read
            S_DECODE: begin
                n_res   = '{ST_RANGE, '0, '0, '0, '0};
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_op)
                    OP_RECORD: begin
                        if (!r_enable || r_halted) begin
                            n_res.status = ST_OFF;
                        end else if (offset >= PC_W'(r_text_span) ||
                                     offset[PC_W-1:BKT_W+1] != '0) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            n_bkt      = offset[BKT_W:1];
                            head_raddr = offset[BKT_W:1];
                            n_done     = 1'b0;
                            n_state    = S_HEAD;
                        end
                    end
                    OP_RD_HEAD: begin
                        if (32'(r_index) < BUCKETS) begin
                            head_raddr = r_index[BKT_W-1:0];
                            n_done     = 1'b0;
                            n_state    = S_RD_HEAD;
                        end
                    end
                    OP_RD_SLOT: begin
                        if (32'(r_index) < SLOTS) begin
                            slot_raddr = r_index[SLOT_W-1:0];
                            n_done     = 1'b0;
                            n_state    = S_RD_SLOT;
                        end
                    end
                    default: begin
                        n_res.status = ST_RANGE;
                    end
                endcase
            end

            // bucket head read result
            S_RD_HEAD: begin
                n_res   = '{ST_HEAD, r_hq, '0, '0, '0};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            // slot read result
            S_RD_SLOT: begin
                n_res   = '{ST_HEAD, r_index[SLOT_W-1:0], r_cq, r_nq, r_lq};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            // chain head known, fetch its slot
            S_HEAD: begin
                n_head = r_hq;
                if (r_hq != '0) begin
                    slot_raddr = r_hq;
                    n_state    = S_CMP_HEAD;
                end else begin
                    n_state = S_ALLOC;
                end
            end

            // compare against the head slot
            S_CMP_HEAD: begin
                if (r_cq == r_callee) begin
                    cnt_we     = 1'b1;
                    slot_waddr = r_head;
                    cnt_wdata  = cnt_bumped;
                    n_res      = '{ST_HEAD, r_head, '0, cnt_bumped, '0};
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_prev  = r_head;
                    n_cur   = r_lq;
                    n_steps = '0;
                    n_state = S_WALK;
                end
            end

            // next chain link, stop at chain end or step limit
            S_WALK: begin
                if (r_steps == STEP_W'(SLOTS) || r_cur == '0) begin
                    n_state = S_ALLOC;
                end else begin
                    slot_raddr = r_cur;
                    n_state    = S_WCMP;
                end
            end

            // compare against a chain slot
            S_WCMP: begin
                if (r_cq == r_callee) begin
                    n_cnt   = cnt_bumped;
                    n_nlink = r_lq;
                    n_state = S_MOVE1;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_lq;
                    n_steps = r_steps + STEP_W'(1);
                    n_state = S_WALK;
                end
            end

            // unlink the hit slot and make it the head
            S_MOVE1: begin
                cnt_we     = 1'b1;
                slot_waddr = r_cur;
                cnt_wdata  = r_cnt;
                link_we    = 1'b1;
                link_waddr = r_prev;
                link_wdata = r_nlink;
                head_we    = 1'b1;
                head_waddr = r_bkt;
                head_wdata = r_cur;
                n_state    = S_MOVE2;
            end

            // point the moved slot at the old head
            S_MOVE2: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                link_wdata = r_head;
                n_res      = '{ST_MOVED, r_cur, '0, r_cnt, '0};
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end

            // take the next free slot or halt on overflow
            S_ALLOC: begin
                n_next_free = alloc_idx[NF_W-1:0];
                n_done      = 1'b1;
                n_state     = S_IDLE;
                if (alloc_idx >= {1'b0, r_arc_limit} ||
                    alloc_idx >= (NF_W+1)'(SLOTS)) begin
                    n_halted = 1'b1;
                    n_res    = '{ST_OVF, '0, '0, '0, '0};
                end else begin
                    slot_we      = 1'b1;
                    cnt_we       = 1'b1;
                    slot_waddr   = alloc_idx[SLOT_W-1:0];
                    callee_wdata = r_callee;
                    cnt_wdata    = CNT_W'(1);
                    link_we      = 1'b1;
                    link_waddr   = alloc_idx[SLOT_W-1:0];
                    link_wdata   = r_head;
                    head_we      = 1'b1;
                    head_waddr   = r_bkt;
                    head_wdata   = alloc_idx[SLOT_W-1:0];
                    n_res        = '{ST_NEW, alloc_idx[SLOT_W-1:0], '0, CNT_W'(1), '0};
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
    import car_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE = 20;

    // one directed row: a register write or an item, optionally with a typed answer
    typedef struct {
        bit          is_reg;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        t_item       it;
        bit          typed;
        t_result     res;
    } stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_item               i_item;
    logic                o_done;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    call_arc_recorder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // register shadows
    logic [PC_W-1:0]   reg_base   = '0;
    logic [SPAN_W-1:0] reg_span   = '0;
    logic [NF_W-1:0]   reg_limit  = ARC_LIMIT_RST;
    logic              reg_enable = 1'b0;

    // own copy of the arc table
    logic [SLOT_W-1:0] tbl_head   [BUCKETS];
    logic [PC_W-1:0]   tbl_callee [SLOTS];
    logic [CNT_W-1:0]  tbl_count  [SLOTS];
    logic [SLOT_W-1:0] tbl_link   [SLOTS];
    logic [NF_W-1:0]   tbl_next_free = '0;
    logic              tbl_halted    = 1'b0;
    int                live_slots[$];

    t_result           answers_due[$];
    int                n_fault = 0;
    bit                gaps_on = 1'b1;
    logic [PC_W-1:0]   caller_pool [6];
    logic [PC_W-1:0]   callee_pool [5];
    stim_row           dir_tab[$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
        n_fault++;
        if (n_fault <= 10) begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    // arc table behavior for one transaction
    function automatic t_result arc_table_step(input t_item it);
        t_result           r;
        logic [PC_W-1:0]   off;
        logic [BKT_W-1:0]  bkt;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] prev;
        logic [NF_W:0]     nidx;
        bit                found;
        r = '0;
        r.status = ST_RANGE;
        case (it.opcode)
            OP_RECORD: begin
                off = it.caller_pc - reg_base;
                bkt = off[BKT_W:1];
                if (!reg_enable || tbl_halted) begin
                    r.status = ST_OFF;
                end else if (off < PC_W'(reg_span) && off[PC_W-1:1] < BUCKETS) begin
                    head = tbl_head[bkt];
                    found = 1'b0;
                    // hit at the head of the chain
                    if (head != '0 && tbl_callee[head] == it.callee_pc) begin
                        if (tbl_count[head] != '1) tbl_count[head]++;
                        r.status = ST_HEAD;
                        r.slot = head;
                        r.arc_count = tbl_count[head];
                        found = 1'b1;
                    end else if (head != '0) begin
                        // walk the chain, move a hit to the front
                        prev = head;
                        for (int n = 0; n < SLOTS && !found; n++) begin
                            cur = tbl_link[prev];
                            if (cur == '0) break;
                            if (tbl_callee[cur] == it.callee_pc) begin
                                if (tbl_count[cur] != '1) tbl_count[cur]++;
                                tbl_link[prev] = tbl_link[cur];
                                tbl_link[cur] = head;
                                tbl_head[bkt] = cur;
                                r.status = ST_MOVED;
                                r.slot = cur;
                                r.arc_count = tbl_count[cur];
                                found = 1'b1;
                            end else begin
                                prev = cur;
                            end
                        end
                    end
                    // miss: take the next free slot or halt on overflow
                    if (!found) begin
                        nidx = {1'b0, tbl_next_free} + 1'b1;
                        tbl_next_free = nidx[NF_W-1:0];
                        if (nidx >= {1'b0, reg_limit} || nidx >= SLOTS) begin
                            tbl_halted = 1'b1;
                            r.status = ST_OVF;
                        end else begin
                            cur = nidx[SLOT_W-1:0];
                            tbl_callee[cur] = it.callee_pc;
                            tbl_count[cur] = 1;
                            tbl_link[cur] = head;
                            tbl_head[bkt] = cur;
                            live_slots.push_back(int'(cur));
                            r.status = ST_NEW;
                            r.slot = cur;
                            r.arc_count = 1;
                        end
                    end
                end
            end
            OP_RD_HEAD: begin
                r.status = ST_HEAD;
                r.slot = tbl_head[it.index];
            end
            OP_RD_SLOT: begin
                if (it.index < SLOTS) begin
                    r.status = ST_HEAD;
                    r.slot = it.index[SLOT_W-1:0];
                    r.callee_out = tbl_callee[it.index[SLOT_W-1:0]];
                    r.arc_count = tbl_count[it.index[SLOT_W-1:0]];
                    r.next_link = tbl_link[it.index[SLOT_W-1:0]];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                note_fault("result with nothing pending", '0, 32'(o_result));
            end else begin
                want = answers_due.pop_front();
                if (o_result.status !== want.status)
                    note_fault("field status", 32'(want.status), 32'(o_result.status));
                if (o_result.slot !== want.slot)
                    note_fault("field slot", 32'(want.slot), 32'(o_result.slot));
                if (o_result.callee_out !== want.callee_out)
                    note_fault("field callee_out", want.callee_out, o_result.callee_out);
                if (o_result.arc_count !== want.arc_count)
                    note_fault("field arc_count", want.arc_count, o_result.arc_count);
                if (o_result.next_link !== want.next_link)
                    note_fault("field next_link", 32'(want.next_link), 32'(o_result.next_link));
            end
        end
    end

    // one item transaction, then maybe an idle burst
    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        t_result want;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = arc_table_step(it);
        answers_due.push_back(typed ? typed_res : want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // apb write once the block has drained
    task automatic write_reg(input logic [1:0] ridx, input logic [31:0] v);
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'({ridx, 2'b00});
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (ridx)
            REG_TEXT_BASE: reg_base = v;
            REG_TEXT_SPAN: reg_span = v[SPAN_W-1:0];
            REG_ARC_LIMIT: reg_limit = v[NF_W-1:0];
            REG_ENABLE:    reg_enable = v[0];
            default: begin
            end
        endcase
    endtask

    // callers in adjacent pairs, sharing a bucket when the lower offset is even, plus a few callees
    function automatic void make_pools();
        int k;
        for (int i = 0; i < 3; i++) begin
            k = (reg_span < 2) ? 0 : int'($urandom_range(0, int'(reg_span) - 2));
            caller_pool[2*i] = reg_base + k;
            caller_pool[2*i+1] = reg_base + k + 1;
        end
        callee_pool[0] = '0;
        callee_pool[1] = '1;
        for (int i = 2; i < 5; i++) callee_pool[i] = $urandom;
    endfunction

    // mostly pooled records, then reads and noise
    function automatic t_item draw_item(input bit fresh_callee);
        t_item           it;
        int              pick;
        logic [PC_W-1:0] off;
        it.opcode = OP_RECORD;
        it.caller_pc = $urandom;
        it.callee_pc = $urandom;
        it.index = IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            it.caller_pc = caller_pool[$urandom_range(0, 5)];
            if (!fresh_callee) it.callee_pc = callee_pool[$urandom_range(0, 4)];
        end else if (pick < 70) begin
            // raw record, mostly outside the region
        end else if (pick < 80) begin
            it.opcode = OP_RD_HEAD;
            if (pick < 75) begin
                off = caller_pool[$urandom_range(0, 5)] - reg_base;
                it.index = off[BKT_W:1];
            end
        end else if (pick < 95) begin
            it.opcode = OP_RD_SLOT;
            if (live_slots.size() != 0 && pick < 90)
                it.index = IDX_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
            else
                it.index = IDX_W'($urandom_range(SLOTS, 2**IDX_W - 1));
        end else begin
            it.opcode = OP_UNUSED;
        end
        return it;
    endfunction

    function automatic stim_row row_reg(input logic [1:0] ridx, input logic [31:0] v);
        stim_row s;
        s.is_reg = 1'b1;
        s.reg_idx = ridx;
        s.value = v;
        s.it = '0;
        s.typed = 1'b0;
        s.res = '0;
        return s;
    endfunction

    function automatic stim_row row_known(input logic [OP_W-1:0] op, input logic [31:0] caller,
                                          input logic [31:0] callee, input logic [IDX_W-1:0] idx,
                                          input t_status st, input logic [SLOT_W-1:0] slot,
                                          input logic [31:0] cnt);
        stim_row s;
        s.is_reg = 1'b0;
        s.reg_idx = '0;
        s.value = '0;
        s.it.opcode = op;
        s.it.caller_pc = caller;
        s.it.callee_pc = callee;
        s.it.index = idx;
        s.typed = 1'b1;
        s.res = '0;
        s.res.status = st;
        s.res.slot = slot;
        s.res.arc_count = cnt;
        return s;
    endfunction

    function automatic stim_row row_item(input logic [OP_W-1:0] op, input logic [31:0] caller,
                                         input logic [31:0] callee, input logic [IDX_W-1:0] idx);
        stim_row s;
        s = row_known(op, caller, callee, idx, ST_HEAD, '0, '0);
        s.typed = 1'b0;
        return s;
    endfunction

    // stimulus
    initial begin : stimulus
        stim_row row;
        int      n_items;
        start <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        foreach (tbl_head[i]) tbl_head[i] = '0;
        foreach (tbl_callee[i]) begin
            tbl_callee[i] = '0;
            tbl_count[i] = '0;
            tbl_link[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, bad indexes, unused opcode, disabled record
        dir_tab.push_back(row_known(OP_RD_HEAD, '0, '0, '0, ST_HEAD, '0, '0));
        dir_tab.push_back(row_known(OP_RD_HEAD, '0, '0, 12'hFFF, ST_HEAD, '0, '0));
        dir_tab.push_back(row_known(OP_RD_SLOT, '0, '0, 12'hFFF, ST_RANGE, '0, '0));
        dir_tab.push_back(row_known(OP_RD_SLOT, '0, '0, 12'd1024, ST_RANGE, '0, '0));
        dir_tab.push_back(row_known(OP_UNUSED, '1, '1, 12'hFFF, ST_RANGE, '0, '0));
        dir_tab.push_back(row_known(OP_RECORD, '0, '1, '0, ST_OFF, '0, '0));
        // empty region
        dir_tab.push_back(row_reg(REG_ENABLE, 32'd1));
        dir_tab.push_back(row_known(OP_RECORD, '0, '0, '0, ST_RANGE, '0, '0));
        // region wrapping past zero: new arc, head hit, chain moves
        dir_tab.push_back(row_reg(REG_TEXT_BASE, 32'hFFFF_FFF0));
        dir_tab.push_back(row_reg(REG_TEXT_SPAN, 32'd64));
        dir_tab.push_back(row_known(OP_RECORD, 32'h10, 32'h1234_5678, '0, ST_NEW, 10'd1, 32'd1));
        dir_tab.push_back(row_item(OP_RECORD, 32'h11, 32'h1234_5678, '0));
        dir_tab.push_back(row_item(OP_RECORD, 32'h10, 32'hFFFF_FFFF, '0));
        dir_tab.push_back(row_item(OP_RECORD, 32'h10, 32'h0, '0));
        dir_tab.push_back(row_item(OP_RECORD, 32'h11, 32'h1234_5678, '0));
        dir_tab.push_back(row_item(OP_RECORD, 32'h10, 32'hFFFF_FFFF, '0));
        dir_tab.push_back(row_item(OP_RD_HEAD, '0, '0, 12'd16));
        dir_tab.push_back(row_item(OP_RD_SLOT, '0, '0, 12'd1));
        dir_tab.push_back(row_item(OP_RD_SLOT, '0, '0, 12'd2));
        dir_tab.push_back(row_item(OP_RD_SLOT, '0, '0, 12'd3));
        // region edges: first byte, one below, one past the end, last byte
        dir_tab.push_back(row_item(OP_RECORD, 32'hFFFF_FFF0, 32'h1234_5678, '0));
        dir_tab.push_back(row_known(OP_RECORD, 32'hFFFF_FFEF, '0, '0, ST_RANGE, '0, '0));
        dir_tab.push_back(row_known(OP_RECORD, 32'h30, '0, '0, ST_RANGE, '0, '0));
        dir_tab.push_back(row_item(OP_RECORD, 32'h2F, 32'h8000_0000, '0));
        // last bucket, and an offset inside the span but past the buckets
        dir_tab.push_back(row_reg(REG_TEXT_BASE, 32'hFFFF_FFFF));
        dir_tab.push_back(row_reg(REG_TEXT_SPAN, 32'd16383));
        dir_tab.push_back(row_item(OP_RECORD, 32'h1FFE, 32'h1234_5678, '0));
        dir_tab.push_back(row_known(OP_RECORD, 32'h1FFF, '0, '0, ST_RANGE, '0, '0));
        dir_tab.push_back(row_item(OP_RD_HEAD, '0, '0, 12'hFFF));
        // stopped again
        dir_tab.push_back(row_reg(REG_ENABLE, 32'd0));
        dir_tab.push_back(row_known(OP_RECORD, 32'h10, 32'h1234_5678, '0, ST_OFF, '0, '0));

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.is_reg) begin
                write_reg(row.reg_idx, row.value);
            end else begin
                send_item(row.it, row.typed, row.res);
            end
        end

        // random phases; the next to last runs the table into overflow
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_TEXT_BASE, 32'd0);
                    write_reg(REG_TEXT_SPAN, 32'd8192);
                    write_reg(REG_ARC_LIMIT, 32'd1024);
                    write_reg(REG_ENABLE, 32'd1);
                end
                1: begin
                    write_reg(REG_TEXT_BASE, 32'hFFFF_FFFF);
                    write_reg(REG_TEXT_SPAN, 32'd16383);
                    write_reg(REG_ARC_LIMIT, 32'd2047);
                end
                2: begin
                    write_reg(REG_TEXT_BASE, $urandom & 32'hFFFF_FFFC);
                    write_reg(REG_TEXT_SPAN, $urandom_range(1, 8192));
                    write_reg(REG_ARC_LIMIT, 32'd1024);
                end
                3: begin
                    write_reg(REG_TEXT_BASE, $urandom);
                    write_reg(REG_TEXT_SPAN, 32'd1);
                    write_reg(REG_ARC_LIMIT, 32'd2047);
                end
                4: begin
                    write_reg(REG_ENABLE, 32'd0);
                end
                5: begin
                    write_reg(REG_ENABLE, 32'd1);
                    write_reg(REG_TEXT_BASE, 32'd0);
                    write_reg(REG_TEXT_SPAN, 32'd8192);
                    write_reg(REG_ARC_LIMIT, 32'(tbl_next_free) + 32'd6);
                end
                default: begin
                    write_reg(REG_ARC_LIMIT, 32'd1);
                end
            endcase
            make_pools();
            n_items = (ph < 4) ? 140 : (ph == 5) ? 150 : 30;
            for (int n = 0; n < n_items; n++) begin
                gaps_on = (ph < 5) || (ph == 5 && n < 70);
                send_item(draw_item(ph == 5), 1'b0, '0);
            end
        end

        // drain
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_fault == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/car_pkg.sv
rtl/call_arc_recorder.sv
bench/tb.sv
